// ===== hdl/murmur64a_stream_hash_top_macros.svh =====
// ---------------------------------------------------------------------------
// murmur64a_stream_hash_top_macros.svh
// Assertion macros used by the hash block back end (mm64_back).
// ---------------------------------------------------------------------------
`ifndef MURMUR64A_STREAM_HASH_TOP_MACROS_SVH
`define MURMUR64A_STREAM_HASH_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MM64_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MM64_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mm64_pkg.sv =====
// ---------------------------------------------------------------------------
// mm64_pkg
// Shared types and constants of the streaming 64-bit hash block.
// ---------------------------------------------------------------------------
package mm64_pkg;

  localparam logic [63:0] MIX_MUL         = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT       = 47;
  localparam int          LENGTH_BITS_DEF = 32;
  localparam int          LEN_W           = 32;  // width of the length field
  localparam int          WORD_W          = 64;
  localparam int          QUEUE_DEPTH     = 2;

  // Input op codes; code 3 carries no meaning and is dropped.
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_WORD   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  // One classified item waiting between front and back.
  typedef struct packed {
    op_t               kind;
    logic [WORD_W-1:0] operand;  // masked length on start, data word otherwise
  } mm64_item_t;

  // Status of the shared multiply unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mm64_mul_stat_t;

  function automatic logic [WORD_W-1:0] fold47(input logic [WORD_W-1:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

endpackage

// ===== hdl/mm64_mul.sv =====
// ---------------------------------------------------------------------------
// mm64_mul
// Low 64 bits of a 64-bit operand times the mixing constant, built from
// three 32x32 partial products on one shared multiplier.
// ---------------------------------------------------------------------------
module mm64_mul
  import mm64_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,       // held stable until done
  output mm64_mul_stat_t    stat,
  output logic [WORD_W-1:0] product
);

  localparam int HALF_W = WORD_W / 2;
  localparam logic [HALF_W-1:0] M_LO = MIX_MUL[HALF_W-1:0];
  localparam logic [HALF_W-1:0] M_HI = MIX_MUL[WORD_W-1:HALF_W];

  logic              busy;
  logic              done;
  logic [1:0]        step;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] acc;
  logic [HALF_W-1:0] op_x;
  logic [HALF_W-1:0] op_y;

  // Pick the partial product for this step.
  always_comb begin
    case (step)
      2'd0: begin
        op_x = a[HALF_W-1:0];
        op_y = M_LO;
      end
      2'd1: begin
        op_x = a[HALF_W-1:0];
        op_y = M_HI;
      end
      2'd2: begin
        op_x = a[WORD_W-1:HALF_W];
        op_y = M_LO;
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        prod <= WORD_W'(op_x) * WORD_W'(op_y);
        case (step)
          2'd0: begin
          end
          2'd1: begin
            acc <= prod;
          end
          2'd2: begin
            acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
          end
          default: begin
            acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
            busy <= 1'b0;
            done <= 1'b1;
          end
        endcase
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = acc;

endmodule

// ===== hdl/mm64_front.sv =====
// ---------------------------------------------------------------------------
// mm64_front
// Input side: accept beats, classify the op, mask the length and queue
// the item for the back end.
// ---------------------------------------------------------------------------
module mm64_front
  import mm64_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [LEN_W+WORD_W-1:0]  s_tdata,   // msg_length, data_word
  input  logic [1:0]               s_tuser,   // op
  input  logic                     pop,
  output logic                     item_valid,
  output mm64_item_t               item
);

  localparam logic [LEN_W-1:0] LEN_MASK =
    (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mm64_item_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              accept;
  logic              push;
  logic              do_pop;
  mm64_item_t        incoming;

  assign s_tready = (count != CNT_W'(QUEUE_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign do_pop   = pop && item_valid;

  // Classify; drop the unused op code.
  always_comb begin
    incoming.kind    = op_t'(s_tuser);
    incoming.operand = s_tdata[LEN_W +: WORD_W];
    push             = accept;
    case (op_t'(s_tuser))
      OP_START:  incoming.operand = WORD_W'(s_tdata[LEN_W-1:0] & LEN_MASK);
      OP_WORD:   incoming.operand = s_tdata[LEN_W +: WORD_W];
      OP_FINISH: incoming.operand = s_tdata[LEN_W +: WORD_W];
      default:   push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= incoming;
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign item_valid = (count != '0);
  assign item       = entries[rd_ptr];

endmodule

// ===== hdl/mm64_back.sv =====
// ---------------------------------------------------------------------------
// mm64_back
// Execution side: sequence the running hash through the shared multiply
// unit and hold the finished hash in the output register.
// ---------------------------------------------------------------------------
`include "murmur64a_stream_hash_top_macros.svh"

module mm64_back
  import mm64_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] hash_seed,
  input  logic              item_valid,
  input  mm64_item_t        item,
  output logic              pop,
  output logic              mul_start,
  output logic [WORD_W-1:0] mul_a,
  input  mm64_mul_stat_t    mul_stat,
  input  logic [WORD_W-1:0] mul_p,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [WORD_W-1:0] m_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,  // wait for length * M
    S_K1,     // wait for word * M
    S_K2,     // wait for folded word * M
    S_H,      // wait for (hash ^ mixed word) * M
    S_FT,     // wait for (hash ^ tail) * M
    S_FA      // wait for avalanche multiply
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] running_hash;
  logic [2:0]        tail_count;
  logic              out_valid;
  logic [WORD_W-1:0] out_data;

  function automatic logic [WORD_W-1:0] tail_mask(input logic [2:0] n);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (3'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // A finish item only leaves the queue once the output register is free.
  assign pop = (state == S_IDLE) && item_valid &&
               ((item.kind != OP_FINISH) || !out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mul_start    <= 1'b0;
      out_valid    <= 1'b0;
      running_hash <= '0;
      tail_count   <= '0;
    end else begin
      mul_start <= 1'b0;
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (item.kind)
              OP_START: begin
                mul_a      <= item.operand;
                mul_start  <= 1'b1;
                tail_count <= item.operand[2:0];
                state      <= S_START;
              end
              OP_WORD: begin
                mul_a     <= item.operand;
                mul_start <= 1'b1;
                state     <= S_K1;
              end
              OP_FINISH: begin
                mul_start <= 1'b1;
                if (tail_count != '0) begin
                  mul_a <= running_hash ^ (item.operand & tail_mask(tail_count));
                  state <= S_FT;
                end else begin
                  mul_a <= fold47(running_hash);
                  state <= S_FA;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_START: begin
          if (mul_stat.done) begin
            running_hash <= hash_seed ^ mul_p;
            state        <= S_IDLE;
          end
        end
        S_K1: begin
          if (mul_stat.done) begin
            mul_a     <= fold47(mul_p);
            mul_start <= 1'b1;
            state     <= S_K2;
          end
        end
        S_K2: begin
          if (mul_stat.done) begin
            mul_a     <= running_hash ^ mul_p;
            mul_start <= 1'b1;
            state     <= S_H;
          end
        end
        S_H: begin
          if (mul_stat.done) begin
            running_hash <= mul_p;
            state        <= S_IDLE;
          end
        end
        S_FT: begin
          if (mul_stat.done) begin
            mul_a     <= fold47(mul_p);
            mul_start <= 1'b1;
            state     <= S_FA;
          end
        end
        S_FA: begin
          if (mul_stat.done) begin
            out_data  <= fold47(mul_p);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  `MM64_ASSERT_IMP(a_launch_when_free, clk, rst, mul_start, !mul_stat.busy, "multiply launched while busy")
  `MM64_ASSERT_IMP(a_finish_needs_slot, clk, rst, pop && (item.kind == OP_FINISH), !out_valid, "finish popped with output full")
  `MM64_ASSERT_IMP(a_idle_mul_quiet, clk, rst, state == S_IDLE, !mul_stat.busy && !mul_start, "multiply active while idle")
  `MM64_ASSERT_NXT(a_start_sets_tail, clk, rst, pop && (item.kind == OP_START), tail_count == $past(item.operand[2:0]), "tail count not taken from start")

endmodule

// ===== hdl/murmur64a_stream_hash_top.sv =====
// ---------------------------------------------------------------------------
// murmur64a_stream_hash_top
// Streaming 64-bit MurmurHash64A engine with a seed register.
// ---------------------------------------------------------------------------
// Send a message as one start beat (tuser op 0, length in tdata[31:0]),
// any number of word beats (op 1, eight little-endian bytes in
// tdata[95:32]) and one finish beat (op 2, tail bytes in the low bytes of
// tdata[95:32]); the finish beat yields one hash beat on the master side.
// Op 3 beats are accepted and dropped. Write the seed through cfg_we /
// cfg_wdata only while no message is in flight. Every 64-bit product by
// the mixing constant runs on one shared 32x32 multiplier as three
// partial products. A two-entry queue sits between the input side and
// the sequencer, so beats keep being taken while a multiply is in
// progress, and the output register holds a hash until it is taken
// without blocking word beats behind it.
// ---------------------------------------------------------------------------
module murmur64a_stream_hash_top
  import mm64_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // Seed register write port
  input  logic                    cfg_we,
  input  logic [WORD_W-1:0]       cfg_wdata,   // hash_seed
  // Input stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [LEN_W+WORD_W-1:0] s_tdata,     // [31:0] msg_length, [95:32] data_word
  input  logic [1:0]              s_tuser,     // [1:0] op
  // Result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [WORD_W-1:0]       m_tdata      // [63:0] hash_value
);

  logic [WORD_W-1:0] hash_seed;
  logic              item_valid;
  mm64_item_t        item;
  logic              pop;
  logic              mul_start;
  logic [WORD_W-1:0] mul_a;
  mm64_mul_stat_t    mul_stat;
  logic [WORD_W-1:0] mul_p;

  // Seed register: written directly, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed <= '0;
    end else if (cfg_we) begin
      hash_seed <= cfg_wdata;
    end
  end

  // Accept, classify and queue beats.
  mm64_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item)
  );

  // Sequence the hash arithmetic and hold the result beat.
  mm64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .hash_seed  (hash_seed),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .mul_start  (mul_start),
    .mul_a      (mul_a),
    .mul_stat   (mul_stat),
    .mul_p      (mul_p),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // Shared multiply by the mixing constant.
  mm64_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .stat    (mul_stat),
    .product (mul_p)
  );

endmodule

// ===== dv/murmur64a_stream_hash_top_tb.sv =====
// ---------------------------------------------------------------------------
// murmur64a_stream_hash_top_tb
// Self-checking bench for the streaming 64-bit MurmurHash64A engine.
// A queue-fed driver sends start, word, finish and dropped beats. A predictor
// tracks the running hash, the tail count and the seed, and queues the hash
// that each finish beat should give. A monitor compares every result beat
// with the oldest queued hash. Both sides idle in random bursts, the receiver
// holds off once for a long stretch, and the seed is rewritten between
// phases while the engine is idle.
// ---------------------------------------------------------------------------
module murmur64a_stream_hash_top_tb;
  import mm64_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Op 3 has no enum member in the package; the block drops it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 100;   // queue of two plus a word beat in flight
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT  = 3000;  // cycles without any beat before giving up

  typedef struct packed {
    logic [1:0]        op;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } beat_t;

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [WORD_W-1:0]       cfg_wdata = '0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [LEN_W+WORD_W-1:0] s_tdata   = '0;   // [31:0] msg_length, [95:32] data_word
  logic [1:0]              s_tuser   = '0;   // [1:0] op
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [WORD_W-1:0]       m_tdata;          // [63:0] hash_value

  // Stimulus queue and progress counters
  beat_t       beat_q[$];
  int unsigned beats_queued   = 0;
  int unsigned beats_sent     = 0;
  int unsigned items_planned  = 0;   // op 3 beats are not counted
  int unsigned hashes_checked = 0;
  int unsigned seeds_written  = 0;
  int unsigned fail_count     = 0;

  // Idling controls, set by the stimulus process
  logic tx_idle_en  = 1'b0;
  logic rx_idle_en  = 1'b0;
  int   hold_reqs   = 0;

  // Predictor state
  logic [WORD_W-1:0] model_seed = '0;
  logic [WORD_W-1:0] model_hash = '0;
  logic [2:0]        model_tail = '0;
  logic [WORD_W-1:0] hash_expect_q[$];

  murmur64a_stream_hash_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] scramble_word(input logic [WORD_W-1:0] k);
    logic [WORD_W-1:0] t;
    t = k * MIX_MUL;
    t = t ^ (t >> MIX_SHIFT);
    return t * MIX_MUL;
  endfunction

  // Advance the hash state by one accepted beat; queue a hash on finish.
  task automatic hash_model_step(input beat_t b);
    logic [WORD_W-1:0] h;
    logic [WORD_W-1:0] keep;
    case (b.op)
      OP_START: begin
        // Length is LEN_W wide and the bench uses the default LENGTH_BITS, so no masking applies.
        model_hash = model_seed ^ ({{(WORD_W-LEN_W){1'b0}}, b.len} * MIX_MUL);
        model_tail = b.len[2:0];
      end
      OP_WORD: begin
        model_hash = (model_hash ^ scramble_word(b.word)) * MIX_MUL;
      end
      OP_FINISH: begin
        h = model_hash;
        // Fold only the tail bytes; bytes above the tail count are garbage.
        if (model_tail != 3'd0) begin
          keep = (64'd1 << (8 * model_tail)) - 64'd1;
          h    = (h ^ (b.word & keep)) * MIX_MUL;
        end
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_MUL;
        h = h ^ (h >> MIX_SHIFT);
        hash_expect_q.push_back(h);
      end
      default: ;  // dropped beat: state stays as it is
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Driver: offer queued beats, with random gaps when enabled
  // -------------------------------------------------------------------------
  int unsigned tx_gap_left = 0;

  always @(posedge clk) begin : driver
    beat_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      // Predict from the beat that was on the bus at this edge.
      if (s_tvalid && s_tready) begin
        hash_model_step(beat_t'({s_tuser, s_tdata[LEN_W-1:0], s_tdata[LEN_W +: WORD_W]}));
        beats_sent++;
      end
      // Hold a beat that was not taken; otherwise pick the next action.
      if (!(s_tvalid && !s_tready)) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          s_tvalid <= 1'b0;
        end else if (tx_idle_en && $urandom_range(0, 5) == 0) begin
          tx_gap_left = $urandom_range(0, 12);
          s_tvalid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          nxt = beat_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.op;
          s_tdata  <= {nxt.word, nxt.len};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: check each hash beat, drive tready with bursts and the hold-off
  // -------------------------------------------------------------------------
  int unsigned rx_gap_left = 0;
  int unsigned hold_left   = 0;
  int          hold_served = 0;

  always @(posedge clk) begin : monitor
    logic [WORD_W-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        hashes_checked++;
        if (hash_expect_q.size() == 0) begin
          $error("hash_value: no hash expected, actual %h", m_tdata);
          fail_count++;
        end else begin
          want = hash_expect_q.pop_front();
          if (m_tdata !== want) begin
            $error("hash_value mismatch: expected %h, actual %h", want, m_tdata);
            fail_count++;
          end
        end
      end
      // Start a requested hold-off; count it down here.
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        m_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rx_gap_left = $urandom_range(0, 12);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on either side for too long
  // -------------------------------------------------------------------------
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no beat moved for %0d cycles", QUIET_LIMIT);
    $display("murmur64a_stream_hash_top_tb NOT OK");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_beat(input logic [1:0] op, input logic [LEN_W-1:0] len,
                          input logic [WORD_W-1:0] word);
    beat_q.push_back('{op: op, len: len, word: word});
    beats_queued++;
    if (op != OP_UNUSED)
      items_planned++;
  endtask

  // Start, n_words word beats with random content, finish with garbage above
  // the tail bytes. Don't-care fields get random values too.
  task automatic add_message(input logic [LEN_W-1:0] len, input int n_words);
    add_beat(OP_START, len, rand64());
    repeat (n_words) add_beat(OP_WORD, $urandom(), rand64());
    add_beat(OP_FINISH, $urandom(), rand64());
  endtask

  // Mostly well-formed messages; the rest is noise and broken sequences.
  task automatic add_random_items(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    logic [LEN_W-1:0] len;
    stop_at = items_planned + n_items;
    while (items_planned < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 48);
        add_message(len, len >> 3);
      end else if (pick < 83) begin
        add_beat(OP_UNUSED, $urandom(), rand64());
      end else if (pick < 88) begin
        add_beat(OP_WORD, $urandom(), rand64());
      end else if (pick < 93) begin
        add_beat(OP_FINISH, $urandom(), rand64());
      end else if (pick < 97) begin
        add_message($urandom(), $urandom_range(0, 4));
      end else begin
        add_beat(OP_START, $urandom(), rand64());
      end
    end
  endtask

  // Wait until every beat is taken and every hash has come back, then let
  // any trailing word or dropped beats finish inside the engine.
  task automatic settle();
    while (beats_sent != beats_queued || hash_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the seed while the engine is idle; the predictor follows at once.
  task automatic write_seed(input logic [WORD_W-1:0] seed);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    model_seed = seed;
    seeds_written++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;

    // Directed part, seed still at its reset value.
    add_beat(OP_FINISH, '1, '1);          // finish straight out of reset
    add_beat(OP_UNUSED, '1, '1);          // dropped beat, all ones
    add_beat(OP_START, '0, '1);           // empty message: no tail, no words
    add_beat(OP_FINISH, '1, '1);
    add_beat(OP_START, 32'd8, '0);        // one full word, no tail
    add_beat(OP_WORD, '1, '1);
    add_beat(OP_FINISH, '0, '1);
    add_beat(OP_START, '1, '1);           // largest length: tail of seven bytes
    add_beat(OP_WORD, '0, '0);
    add_beat(OP_FINISH, '0, '1);          // top byte is garbage and must be masked
    add_beat(OP_FINISH, '0, '1);          // repeated finish gives the same hash
    add_beat(OP_START, 32'd3, rand64());  // three tail bytes, more words than length
    add_beat(OP_WORD, $urandom(), rand64());
    add_beat(OP_FINISH, $urandom(), 64'hffff_ffff_ff12_3456);
    add_beat(OP_START, 32'd13, rand64()); // dropped beats inside a message
    add_beat(OP_UNUSED, '0, '0);
    add_beat(OP_WORD, $urandom(), rand64());
    add_beat(OP_UNUSED, $urandom(), rand64());
    add_beat(OP_FINISH, $urandom(), rand64());
    add_beat(OP_START, 32'h8000_0000, '0);
    add_beat(OP_WORD, '0, 64'h8000_0000_0000_0000);
    add_beat(OP_FINISH, '1, '0);
    settle();

    // Largest seed, idling on both sides.
    write_seed('1);
    add_random_items(200);
    settle();

    // Random seed; hold the receiver off while the sender keeps pushing short
    // messages, so hashes pile up and the input side backs up.
    write_seed(rand64());
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    hold_reqs  <= hold_reqs + 1;
    repeat (30) add_message($urandom_range(0, 15), 0);
    settle();
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
    add_random_items(120);
    settle();

    // Zero seed, sender idles only.
    write_seed('0);
    rx_idle_en <= 1'b0;
    add_random_items(200);
    settle();

    // Top and bottom seed bits set, receiver idles only.
    write_seed(64'h8000_0000_0000_0001);
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b1;
    add_random_items(200);
    settle();

    // Last part runs without idling on either side.
    write_seed(rand64());
    rx_idle_en <= 1'b0;
    add_random_items(170);
    settle();

    if (hash_expect_q.size() != 0) begin
      $error("hash_value: %0d expected hashes never arrived", hash_expect_q.size());
      fail_count++;
    end
    $display("Sent %0d beats (%0d counted items), checked %0d hashes", beats_sent,
             items_planned, hashes_checked);
    $display("Seed written %0d times, one long receiver hold-off", seeds_written);
    if (fail_count == 0) begin
      $display("murmur64a_stream_hash_top_tb OK");
    end else begin
      $display("murmur64a_stream_hash_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mm64_pkg.sv
hdl/mm64_mul.sv
hdl/mm64_front.sv
hdl/mm64_back.sv
hdl/murmur64a_stream_hash_top.sv
dv/murmur64a_stream_hash_top_tb.sv
